// ===== src/sbsh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbsh_pkg
// shared types, round constants and sigma functions for the sha-256 hasher
// ----------------------------------------------------------------------------
package sbsh_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [7:0][31:0]  wv_t;
  typedef logic [15:0][31:0] sched_t;

  localparam wv_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LAST_REST = 6'd55;

  function automatic word_t ror32(input word_t x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== src/sbsh_round.sv =====
// ----------------------------------------------------------------------------
// sbsh_round
// one sha-256 round with the rolling message schedule step
// ----------------------------------------------------------------------------
module sbsh_round import sbsh_pkg::*; (
  input  wv_t   wv_i,
  input  word_t w0_i,
  input  word_t w1_i,
  input  word_t w9_i,
  input  word_t w14_i,
  input  word_t k_i,
  input  logic  sched_en_i,
  output wv_t   wv_o,
  output word_t wt_o
);

  word_t wt;
  word_t ch;
  word_t maj;
  word_t t1;
  word_t t2;

  always_comb begin
    // past round 15 the schedule word is expanded from the taps
    if (sched_en_i) begin
      wt = w0_i + small_sigma0(w1_i) + w9_i + small_sigma1(w14_i);
    end else begin
      wt = w0_i;
    end
    ch  = (wv_i[4] & wv_i[5]) ^ (~wv_i[4] & wv_i[6]);
    maj = (wv_i[0] & wv_i[1]) ^ (wv_i[0] & wv_i[2]) ^ (wv_i[1] & wv_i[2]);
    t1  = wv_i[7] + big_sigma1(wv_i[4]) + ch + k_i + wt;
    t2  = big_sigma0(wv_i[0]) + maj;
    wv_o[7] = wv_i[6];
    wv_o[6] = wv_i[5];
    wv_o[5] = wv_i[4];
    wv_o[4] = wv_i[3] + t1;
    wv_o[3] = wv_i[2];
    wv_o[2] = wv_i[1];
    wv_o[1] = wv_i[0];
    wv_o[0] = t1 + t2;
    wt_o    = wt;
  end

endmodule

// ===== src/sha256_byte_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// sha-256 over a byte stream, digest out as eight 32-bit words
// ----------------------------------------------------------------------------
// A byte transaction is taken only while the hasher is idle. The byte that
// fills a 64-byte block holds the input off while the single round unit runs
// 64 rounds, one per cycle, and then adds the result into the hash words. A
// final transaction pads and compresses one final block, or two when fewer
// than nine bytes remain free in the block, then presents the eight digest
// words, one per cycle when the output is not stalled. After word 7 the hash
// returns to its initial values.
module sha256_byte_stream_hasher_top import sbsh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_done
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ROUND  = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_PAD    = 3'd3;
  localparam logic [2:0] ST_LEN    = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_TO_PAD = 2'd1;
  localparam logic [1:0] PH_TO_LEN = 2'd2;
  localparam logic [1:0] PH_DIGEST = 2'd3;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [60:0] count_r, count_nxt;
  wv_t         hash_r, hash_nxt;
  wv_t         wv_r, wv_nxt;
  sched_t      w_r, w_nxt;

  wv_t         wv_round;
  word_t       wt_round;
  logic        in_take;
  logic        out_take;
  logic [63:0] bit_len;
  logic [5:0]  rest;
  logic [5:0]  pos;

  sbsh_round u_round (
    .wv_i       (wv_r),
    .w0_i       (w_r[0]),
    .w1_i       (w_r[1]),
    .w9_i       (w_r[9]),
    .w14_i      (w_r[14]),
    .k_i        (ROUND_K[round_r]),
    .sched_en_i (round_r[5] | round_r[4]),
    .wv_o       (wv_round),
    .wt_o       (wt_round)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign in_take         = in_valid && !in_stall;
  assign out_valid       = (state_r == ST_OUT);
  assign out_take        = out_valid && !out_stall;
  assign out_digest_word = hash_r[0];
  assign out_word_index  = idx_r;
  assign out_digest_done = (idx_r == 3'd7);
  assign bit_len         = {count_r, 3'b000};
  assign rest            = count_r[5:0];

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    round_nxt = round_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    hash_nxt  = hash_r;
    wv_nxt    = wv_r;
    w_nxt     = w_r;
    pos       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_byte_present) begin
            for (int j = 0; j < 16; j++) begin
              for (int b = 0; b < 4; b++) begin
                if (count_r[5:2] == 4'(j) && count_r[1:0] == 2'(b)) begin
                  w_nxt[j][31-8*b -: 8] = in_data_byte;
                end
              end
            end
            count_nxt = count_r + 61'd1;
            if (count_r[5:0] == 6'h3f) begin
              // block full: compress, then finish if this was the last byte
              wv_nxt    = hash_r;
              round_nxt = '0;
              phase_nxt = in_message_end ? PH_TO_PAD : PH_NORMAL;
              state_nxt = ST_ROUND;
            end else if (in_message_end) begin
              state_nxt = ST_PAD;
            end
          end else if (in_message_end) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        wv_nxt    = wv_round;
        w_nxt     = {wt_round, w_r[15:1]};
        round_nxt = round_r + 6'd1;
        if (round_r == 6'd63) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        for (int j = 0; j < 8; j++) begin
          hash_nxt[j] = hash_r[j] + wv_r[j];
        end
        unique case (phase_r)
          PH_NORMAL: state_nxt = ST_IDLE;
          PH_TO_PAD: state_nxt = ST_PAD;
          PH_TO_LEN: state_nxt = ST_LEN;
          PH_DIGEST: begin
            idx_nxt   = '0;
            state_nxt = ST_OUT;
          end
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_PAD: begin
        for (int j = 0; j < 16; j++) begin
          for (int b = 0; b < 4; b++) begin
            pos = 6'(4 * j + b);
            if (pos == rest) begin
              w_nxt[j][31-8*b -: 8] = PAD_BYTE;
            end else if (pos > rest) begin
              w_nxt[j][31-8*b -: 8] = 8'h00;
            end
          end
        end
        wv_nxt    = hash_r;
        round_nxt = '0;
        state_nxt = ST_ROUND;
        if (rest <= LAST_REST) begin
          w_nxt[14] = bit_len[63:32];
          w_nxt[15] = bit_len[31:0];
          phase_nxt = PH_DIGEST;
        end else begin
          // no room for the length: it goes in a block of its own
          phase_nxt = PH_TO_LEN;
        end
      end
      ST_LEN: begin
        w_nxt      = '0;
        w_nxt[14]  = bit_len[63:32];
        w_nxt[15]  = bit_len[31:0];
        wv_nxt     = hash_r;
        round_nxt  = '0;
        phase_nxt  = PH_DIGEST;
        state_nxt  = ST_ROUND;
      end
      ST_OUT: begin
        if (out_take) begin
          hash_nxt = {hash_r[0], hash_r[7:1]};
          idx_nxt  = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            hash_nxt  = INIT_H;
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_NORMAL;
      round_r <= '0;
      idx_r   <= '0;
      count_r <= '0;
      hash_r  <= INIT_H;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      round_r <= round_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      hash_r  <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wv_r <= wv_nxt;
    w_r  <= w_nxt;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives byte transactions into the sha-256 stream hasher, keeps its own
// sha-256 state and checks each digest word against the expected digest
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] dword;
    logic [2:0]  idx;
    logic        done;
  } digest_word_t;

  localparam logic [0:63][31:0] SHA_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam int MSG_ITEM_TARGET = 370;
  localparam int QUIET_TAIL      = 40;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_CYCLES    = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_message_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_digest_done;

  sha256_byte_stream_hasher_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_message_end  (in_message_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_digest_done (out_digest_done)
  );

  always #1 clk = ~clk;

  // stimulus and expected digests
  byte_item_t   pending_bytes[$];
  digest_word_t digest_q[$];

  // predictor state
  logic [31:0] h_state [8];
  logic [7:0]  blk_bytes [64];
  logic [60:0] msg_bytes;

  int n_total;
  int n_msg_items;
  int n_noise;
  int n_messages;
  int n_accepted;
  int failures;
  int words_seen;
  bit quiet;
  int gap_left;
  int stall_left;
  bit long_hold_done;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, w15, w2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    for (int j = 0; j < 8; j++) v[j] = h_state[j];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        // rolling 16-word schedule
        w15 = w[(t - 15) % 16];
        w2  = w[(t - 2) % 16];
        wt = w[t % 16] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w[(t - 7) % 16]
           + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
        w[t % 16] = wt;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) h_state[j] = h_state[j] + v[j];
  endfunction

  function automatic void hash_byte_item(input byte_item_t it);
    logic [5:0]   rest;
    logic [63:0]  bit_len;
    digest_word_t dw;
    if (it.present) begin
      blk_bytes[msg_bytes[5:0]] = it.data;
      msg_bytes = msg_bytes + 1'b1;
      if (msg_bytes[5:0] == 6'd0) compress_block();
    end
    if (it.last) begin
      rest = msg_bytes[5:0];
      blk_bytes[rest] = 8'h80;
      for (int i = rest + 1; i < 64; i++) blk_bytes[i] = 8'h00;
      // no room left for the length field
      if (rest > 6'd55) begin
        compress_block();
        for (int i = 0; i < 56; i++) blk_bytes[i] = 8'h00;
      end
      bit_len = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++) blk_bytes[63 - i] = bit_len[8*i +: 8];
      compress_block();
      for (int j = 0; j < 8; j++) begin
        dw.dword = h_state[j];
        dw.idx   = j[2:0];
        dw.done  = (j == 7);
        digest_q = {digest_q, dw};
        h_state[j] = SHA_IV[j];
      end
      msg_bytes = '0;
    end
  endfunction

  task automatic queue_item(input logic [7:0] data, input logic present, input logic last);
    byte_item_t it;
    it.data    = data;
    it.present = present;
    it.last    = last;
    pending_bytes = {pending_bytes, it};
    n_total++;
    if (!present && !last) n_noise++;
    else n_msg_items++;
    if (last) n_messages++;
  endtask

  task automatic queue_message(input int len);
    bit split_end;
    split_end = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      queue_item(8'($urandom_range(0, 255)), 1'b1, !split_end && (i == len - 1));
    end
    if (split_end) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic int pick_length();
    int boundary_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8);
      1: return boundary_lens[$urandom_range(0, 9)];
      2: return $urandom_range(0, 140);
      default: return $urandom_range(9, 40);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_data_byte    <= 8'h00;
      in_byte_present <= 1'b0;
      in_message_end  <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        hash_byte_item({in_data_byte, in_byte_present, in_message_end});
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_valid        <= 1'b1;
          in_data_byte    <= pending_bytes[0].data;
          in_byte_present <= pending_bytes[0].present;
          in_message_end  <= pending_bytes[0].last;
          void'(pending_bytes.pop_front());
          if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
      quiet <= (pending_bytes.size() < QUIET_TAIL);
    end
  end

  // receiver stall: short random bursts, plus one long hold while bytes keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (!long_hold_done && out_valid && words_seen >= 56) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $error("digest word with no transaction pending: %h", out_digest_word);
        failures++;
      end else begin
        want = digest_q.pop_front();
        if (out_digest_word !== want.dword) begin
          $error("digest_word: expected %h, got %h", want.dword, out_digest_word);
          failures++;
        end
        if (out_word_index !== want.idx) begin
          $error("word_index: expected %0d, got %0d", want.idx, out_word_index);
          failures++;
        end
        if (out_digest_done !== want.done) begin
          $error("digest_done: expected %0d, got %0d", want.done, out_digest_done);
          failures++;
        end
      end
      words_seen <= words_seen + 1;
    end
  end

  initial begin
    for (int j = 0; j < 8; j++) h_state[j] = SHA_IV[j];
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    msg_bytes = '0;
    n_total = 0; n_msg_items = 0; n_noise = 0; n_messages = 0;
    n_accepted = 0; failures = 0; words_seen = 0;
    quiet = 1'b0; long_hold_done = 1'b0;

    // empty message, single extreme bytes, ignored bytes, abc, byte then empty end, 80 7f
    queue_item(8'h00, 1'b0, 1'b1);
    queue_item(8'h00, 1'b1, 1'b1);
    queue_item(8'hff, 1'b1, 1'b1);
    queue_item(8'ha5, 1'b0, 1'b0);
    queue_item(8'h5a, 1'b0, 1'b1);
    queue_item(8'h61, 1'b1, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1);
    queue_item(8'h01, 1'b1, 1'b0);
    queue_item(8'hff, 1'b0, 1'b0);
    queue_item(8'hff, 1'b0, 1'b1);
    queue_item(8'h80, 1'b1, 1'b0);
    queue_item(8'h7f, 1'b1, 1'b1);

    while (n_msg_items < MSG_ITEM_TARGET) queue_message(pick_length());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (n_accepted < n_total || digest_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("hashed %0d messages from %0d byte transactions, %0d ignored bytes",
             n_messages, n_msg_items, n_noise);
    $display("checked %0d digest words, %0d mismatches", words_seen, failures);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout: %0d of %0d transactions accepted", n_accepted, n_total);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
